// File: sv/pngf_pkg.sv
// ----------------------------------------------------------------------------
// pngf_pkg: shared constants and helpers of the prediction filter
// Register map, mode codes and the per-component predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package pngf_pkg;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_LEN_W  = 10;
    localparam int CFG_ROWS_W = 13;
    localparam int ROW_W      = 12;
    localparam int MAX_ROWS   = 4096;
    localparam int PIX_W      = 24;

    // register indexes (byte address divided by four)
    localparam logic [1:0] REG_FILTER_MODE = 2'd0;
    localparam logic [1:0] REG_DIRECTION   = 2'd1;
    localparam logic [1:0] REG_ROW_LENGTH  = 2'd2;
    localparam logic [1:0] REG_ROW_COUNT   = 2'd3;

    // filter mode codes
    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_LEFT  = 3'd1;
    localparam logic [2:0] MODE_UP    = 3'd2;
    localparam logic [2:0] MODE_AVG   = 3'd3;
    localparam logic [2:0] MODE_PAETH = 3'd4;

    localparam logic DIR_FORWARD = 1'b0;
    localparam logic DIR_INVERSE = 1'b1;

    // Paeth: pick the neighbor closest to left + up - upleft
    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [10:0] da;
        logic signed [10:0] db;
        logic signed [10:0] dc;
        logic [10:0]        pa;
        logic [10:0]        pb;
        logic [10:0]        pc;
        da = $signed({3'b000, b}) - $signed({3'b000, c});
        db = $signed({3'b000, a}) - $signed({3'b000, c});
        dc = da + db;
        pa = (da < 0) ? 11'(-da) : 11'(da);
        pb = (db < 0) ? 11'(-db) : 11'(db);
        pc = (dc < 0) ? 11'(-dc) : 11'(dc);
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end else begin
            return c;
        end
    endfunction

    function automatic logic [7:0] predict(input logic [2:0] mode, input logic [7:0] a,
                                           input logic [7:0] b, input logic [7:0] c);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        case (mode)
            MODE_LEFT:  return a;
            MODE_UP:    return b;
            MODE_AVG:   return sum[8:1];
            MODE_PAETH: return paeth(a, b, c);
            default:    return 8'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

// File: sv/pngf_line_store.sv
// ----------------------------------------------------------------------------
// pngf_line_store: one-row pixel memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pngf_line_store #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9,
    parameter int DATA_W = 24
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: sv/png_style_prediction_filter.sv
// ----------------------------------------------------------------------------
// png_style_prediction_filter: PNG-style scanline prediction filter
// Forward (residual) or inverse (reconstruction) none/left/up/average/Paeth
// filtering of three-component 8-bit pixels in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one pixel per transaction, tdata = {third, second,
//   first}, tuser = frame_start (restart at the first pixel of a frame).
//   Output stream m_*: one result per input, tdata = {third, second, first},
//   tlast marks the final pixel of the frame (row_count-1, row_length-1).
//   Configure filter_mode, direction, row_length and row_count over APB
//   (byte addresses 0, 4, 8, 12) only while the block is idle.
//   An accepted pixel passes through the stage 1 registers and is written
//   into the output queue; with the queue empty it is offered on m_* as
//   soon as it has been written there.
//   Throughput: one pixel per cycle while s_tready is high; the line store
//   delivers the up neighbor as registered read data of the read issued at
//   acceptance; left and up-left sit in registers, and the one-pixel-wide row
//   case is served by forwarding the previous stored pixel.
//   The result feeds a three-entry output queue; s_tready drops only when
//   that queue plus the pixel in flight would overflow, so a stalled
//   receiver holds the queue and stops input after at most three pixels.
//   Reset clears position counters, neighbor registers, the queue and the
//   registers to their defaults; the line store is not cleared (the first
//   row ignores its read data in every mode).
// ----------------------------------------------------------------------------
`default_nettype none

module png_style_prediction_filter #(
    parameter int MAX_ROW_LENGTH = 512
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] in_first, [15:8] in_second, [23:16] in_third
    input  wire logic        s_tuser,   // [0] frame_start
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] out_first, [15:8] out_second, [23:16] out_third
    output logic             m_tlast,   // last_of_frame
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int COL_W   = $clog2(MAX_ROW_LENGTH);
    localparam int LEN_W   = $clog2(MAX_ROW_LENGTH + 1);
    localparam int WW      = (LEN_W > pngf_pkg::CFG_LEN_W) ? LEN_W : pngf_pkg::CFG_LEN_W;
    localparam int RW      = pngf_pkg::CFG_ROWS_W;
    localparam int QDEPTH  = 3;
    localparam int QW      = pngf_pkg::PIX_W + 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [2:0]                     filter_mode_reg;
    logic                           direction_reg;
    logic [pngf_pkg::CFG_LEN_W-1:0] row_length_reg;
    logic [RW-1:0]                  row_count_reg;
    logic                           cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_mode_reg <= pngf_pkg::MODE_NONE;
            direction_reg   <= pngf_pkg::DIR_FORWARD;
            row_length_reg  <= pngf_pkg::CFG_LEN_W'(256);
            row_count_reg   <= RW'(1);
        end else if (cfg_wr) begin
            case (paddr[3:2])
                pngf_pkg::REG_FILTER_MODE: filter_mode_reg <= pwdata[2:0];
                pngf_pkg::REG_DIRECTION:   direction_reg   <= pwdata[0];
                pngf_pkg::REG_ROW_LENGTH:  row_length_reg  <= pwdata[pngf_pkg::CFG_LEN_W-1:0];
                pngf_pkg::REG_ROW_COUNT:   row_count_reg   <= pwdata[RW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            pngf_pkg::REG_FILTER_MODE: prdata = 32'(filter_mode_reg);
            pngf_pkg::REG_DIRECTION:   prdata = 32'(direction_reg);
            pngf_pkg::REG_ROW_LENGTH:  prdata = 32'(row_length_reg);
            pngf_pkg::REG_ROW_COUNT:   prdata = 32'(row_count_reg);
            default:                   prdata = 32'd0;
        endcase
    end

    // effective geometry: zero acts as one, oversize is clamped
    logic [WW-1:0] w_eff;
    logic [RW-1:0] r_eff;

    always_comb begin
        if (row_length_reg == '0) begin
            w_eff = WW'(1);
        end else if (WW'(row_length_reg) > WW'(MAX_ROW_LENGTH)) begin
            w_eff = WW'(MAX_ROW_LENGTH);
        end else begin
            w_eff = WW'(row_length_reg);
        end
        if (row_count_reg == '0) begin
            r_eff = RW'(1);
        end else if (row_count_reg > RW'(pngf_pkg::MAX_ROWS)) begin
            r_eff = RW'(pngf_pkg::MAX_ROWS);
        end else begin
            r_eff = row_count_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 0: acceptance, position tracking, line store read
    // ------------------------------------------------------------------
    logic [COL_W-1:0]          col_reg;
    logic [pngf_pkg::ROW_W-1:0] row_reg;
    logic                      s_accept;

    logic [COL_W-1:0]           col_in;
    logic [pngf_pkg::ROW_W-1:0] row_in;
    logic                       wrap_in;
    logic [COL_W-1:0]           col_cur;
    logic [RW-1:0]              row_inc;
    logic [pngf_pkg::ROW_W-1:0] row_cur;
    logic [WW-1:0]              col_p1;
    logic [RW-1:0]              row_p1;
    logic [COL_W-1:0]           col_next;
    logic [pngf_pkg::ROW_W-1:0] row_next;
    logic                       pred_en;
    logic                       last_cur;
    logic                       fwd;

    always_comb begin
        col_in  = s_tuser ? '0 : col_reg;
        row_in  = s_tuser ? '0 : row_reg;
        wrap_in = (WW'(col_in) >= w_eff);
        col_cur = wrap_in ? '0 : col_in;
        row_inc = RW'(row_in) + RW'(wrap_in);
        row_cur = (row_inc >= r_eff) ? '0 : row_inc[pngf_pkg::ROW_W-1:0];

        // advance to the next position, wrapping at row and frame end
        col_p1 = WW'(col_cur) + WW'(1);
        row_p1 = RW'(row_cur) + RW'(1);
        if (col_p1 >= w_eff) begin
            col_next = '0;
            row_next = (row_p1 >= r_eff) ? '0 : row_p1[pngf_pkg::ROW_W-1:0];
        end else begin
            col_next = col_p1[COL_W-1:0];
            row_next = row_cur;
        end

        last_cur = (RW'(row_cur) == r_eff - RW'(1)) && (WW'(col_cur) == w_eff - WW'(1));

        case (filter_mode_reg)
            pngf_pkg::MODE_LEFT:  pred_en = (row_cur != '0) || (col_cur != '0);
            pngf_pkg::MODE_UP:    pred_en = (row_cur != '0);
            pngf_pkg::MODE_AVG,
            pngf_pkg::MODE_PAETH: pred_en = (row_cur >= pngf_pkg::ROW_W'(2)) ||
                                            ((row_cur == pngf_pkg::ROW_W'(1)) && (col_cur != '0));
            default:              pred_en = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // stage 1 registers
    // ------------------------------------------------------------------
    logic                       s1_valid_reg;
    logic [pngf_pkg::PIX_W-1:0] s1_x_reg;
    logic [COL_W-1:0]           s1_col_reg;
    logic                       s1_pred_en_reg;
    logic                       s1_last_reg;
    logic                       s1_fwd_reg;

    // the pixel in stage 1 writes the same entry this read addresses
    assign fwd = s1_valid_reg && (s1_col_reg == col_cur);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept;
            if (s_accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_x_reg       <= s_tdata;
            s1_col_reg     <= col_cur;
            s1_pred_en_reg <= pred_en;
            s1_last_reg    <= last_cur;
            s1_fwd_reg     <= fwd;
        end
    end

    // ------------------------------------------------------------------
    // line store
    // ------------------------------------------------------------------
    logic [pngf_pkg::PIX_W-1:0] up_rd;
    logic [pngf_pkg::PIX_W-1:0] stored;

    pngf_line_store #(
        .DEPTH  (MAX_ROW_LENGTH),
        .ADDR_W (COL_W),
        .DATA_W (pngf_pkg::PIX_W)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (stored),
        .rd_en   (s_accept),
        .rd_addr (col_cur),
        .rd_data (up_rd)
    );

    // ------------------------------------------------------------------
    // stage 1: predict and apply per component
    // ------------------------------------------------------------------
    logic [pngf_pkg::PIX_W-1:0] left_reg;
    logic [pngf_pkg::PIX_W-1:0] upleft_reg;
    logic [pngf_pkg::PIX_W-1:0] up_px;
    logic [pngf_pkg::PIX_W-1:0] result;

    always_comb begin
        logic [7:0] pred;
        // previous pixel shared the column: take its stored value
        up_px = s1_fwd_reg ? left_reg : up_rd;
        for (int k = 0; k < 3; k++) begin
            pred = s1_pred_en_reg ?
                   pngf_pkg::predict(filter_mode_reg, left_reg[8*k +: 8],
                                     up_px[8*k +: 8], upleft_reg[8*k +: 8]) : 8'd0;
            result[8*k +: 8] = (direction_reg == pngf_pkg::DIR_INVERSE) ?
                               s1_x_reg[8*k +: 8] + pred : s1_x_reg[8*k +: 8] - pred;
        end
        stored = (direction_reg == pngf_pkg::DIR_INVERSE) ? result : s1_x_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= '0;
            upleft_reg <= '0;
        end else if (s1_valid_reg) begin
            left_reg   <= stored;
            upleft_reg <= up_px;
        end
    end

    // ------------------------------------------------------------------
    // output queue: three entries, one for the pixel in flight
    // ------------------------------------------------------------------
    logic [QW-1:0] q_mem_reg [QDEPTH];
    logic [1:0]    q_head_reg;
    logic [1:0]    q_tail_reg;
    logic [1:0]    q_count_reg;
    logic          q_push;
    logic          q_pop;

    function automatic logic [1:0] q_inc(input logic [1:0] p);
        return (p == 2'(QDEPTH - 1)) ? 2'd0 : p + 2'd1;
    endfunction

    assign q_push   = s1_valid_reg;
    assign q_pop    = m_tvalid && m_tready;
    assign m_tvalid = (q_count_reg != 2'd0);
    assign m_tdata  = q_mem_reg[q_head_reg][pngf_pkg::PIX_W-1:0];
    assign m_tlast  = q_mem_reg[q_head_reg][pngf_pkg::PIX_W];

    assign s_tready = ({1'b0, q_count_reg} + {2'b00, s1_valid_reg}) < 3'(QDEPTH);
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (q_push) begin
            q_mem_reg[q_tail_reg] <= {s1_last_reg, result};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_head_reg  <= '0;
            q_tail_reg  <= '0;
            q_count_reg <= '0;
        end else begin
            if (q_push) begin
                q_tail_reg <= q_inc(q_tail_reg);
            end
            if (q_pop) begin
                q_head_reg <= q_inc(q_head_reg);
            end
            q_count_reg <= q_count_reg + 2'(q_push) - 2'(q_pop);
        end
    end

endmodule

`default_nettype wire

// File: sv/pngf_checker.sv
// ----------------------------------------------------------------------------
// pngf_checker: port-level checks of the prediction filter
// No unowed results, bounded occupancy, hold under stall, result after accept.
// ----------------------------------------------------------------------------
`default_nettype none

module pngf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast
);

    logic [2:0] pending_reg;
    logic       s_acc;
    logic       m_acc;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_reg + 3'(s_acc) - 3'(m_acc);
        end
    end

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != 3'd0)
        else $error("result offered with no pixel outstanding");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 3'd3)
        else $error("more than three pixels outstanding");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |-> ##2 m_tvalid)
        else $error("no result two cycles after accepted pixel");

endmodule

bind png_style_prediction_filter pngf_checker u_pngf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
